>>> rtl/seed_signature_pattern_match_core_assert.svh
// assertion macros shared by the seed signature pattern match rtl
`ifndef SEED_SIGNATURE_PATTERN_MATCH_CORE_ASSERT_SVH
`define SEED_SIGNATURE_PATTERN_MATCH_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SSPM_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("sspm assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SSPM_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("sspm assertion failed");

`endif

>>> rtl/sspm_pkg.sv
// widths, register codes and reset values of the seed signature pattern matcher
`timescale 1ns / 1ps

package sspm_pkg;

    localparam int LEN_CFG_W   = 4;
    localparam int SLIDE_CFG_W = 6;
    localparam int SEED_CFG_W  = 3;
    localparam int MASK_W      = 32;
    localparam int MASK_IDX_W  = 5;
    localparam int NUM_MASKS   = 4;
    localparam int MASK_SEL_W  = 2;
    localparam int CNT_W       = 12;
    localparam int INDEX_W     = 11;
    localparam int PATTERN_W   = 12;
    localparam int DIST_W      = 19;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - INDEX_W - PATTERN_W - DIST_W;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_PATTERN_LEN   = 3'd0;
    localparam reg_idx_t REG_SIGNATURE_LEN = 3'd1;
    localparam reg_idx_t REG_SEED_COUNT    = 3'd2;
    localparam reg_idx_t REG_SEED_MASK0    = 3'd3;
    localparam reg_idx_t REG_SEED_MASK1    = 3'd4;
    localparam reg_idx_t REG_SEED_MASK2    = 3'd5;
    localparam reg_idx_t REG_SEED_MASK3    = 3'd6;

    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [LEN_CFG_W-1:0]   LEN_RESET   = 4'd8;
    localparam logic [SLIDE_CFG_W-1:0] SLIDE_RESET = 6'd32;
    localparam logic [SEED_CFG_W-1:0]  SEED_RESET  = 3'd4;

endpackage

>>> rtl/seed_signature_pattern_match_core.sv
// seed signature pattern matcher: build of miss counts and candidate scoring
`timescale 1ns / 1ps

// channel   | dir | contents
// ----------+-----+-------------------------------------------------------------
// apb       | in  | seven config registers at byte address 4*i, always ready
// s_axis    | in  | one word per op: tuser = op, tdata = observed seed bits
// m_axis    | out | one word per op: best index, best pattern, min distance
//
// one shared step unit walks (candidate, seed, slide) triples, one per cycle
// build: the count loop walks every candidate for each seed and slide
// query: each term passes the one-port count table read and then the single
// distance adder
// reset clears the count table at once through per-entry valid bits
// s_axis_tready is high only while idle; a finished word waits in the output
// register and the next word is accepted meanwhile

`include "seed_signature_pattern_match_core_assert.svh"

module seed_signature_pattern_match_core
    import sspm_pkg::*;
#(
    parameter int MAX_PATTERN_LEN   = 12,
    parameter int MAX_SIGNATURE_LEN = 32,
    parameter int NUM_SEEDS         = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // apb config port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // observed_seed0, observed_seed1, observed_seed2, observed_seed3
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // op
    input  logic                   s_axis_tuser,
    // output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // best_index, best_pattern, min_distance, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // candidate index width, pattern width, slide and seed counter widths
    localparam int P_W   = (MAX_PATTERN_LEN > 1) ? MAX_PATTERN_LEN - 1 : 1;
    localparam int L_W   = MAX_PATTERN_LEN;
    localparam int S_W   = (MAX_SIGNATURE_LEN > 1) ? $clog2(MAX_SIGNATURE_LEN) : 1;
    localparam int J_W   = (NUM_SEEDS > 1) ? $clog2(NUM_SEEDS) : 1;
    localparam int DEPTH = MAX_SIGNATURE_LEN * NUM_SEEDS;
    localparam int A_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD,
        ST_QUERY,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // mismatch bits of candidate p: bit 0 set, bit i is bit i-1 of p
    function automatic logic [L_W-1:0] pattern_of(input logic [P_W-1:0] p,
                                                  input logic [LEN_CFG_W-1:0] len);
        logic [L_W-1:0] raw;
        logic [L_W-1:0] keep;
        raw  = L_W'({p, 1'b1});
        keep = ~({L_W{1'b1}} << len);
        return raw & keep;
    endfunction

    // predicted miss at one slide: any set pattern bit over a set care bit
    function automatic logic predict_bit(input logic [L_W-1:0] pat,
                                         input logic [MASK_W-1:0] mask,
                                         input logic [S_W-1:0] s);
        logic hit;
        int   d;
        hit = 1'b0;
        for (int pos = 0; pos < L_W; pos++)
        begin
            d = int'(s) - pos;
            if (d >= 0)
            begin
                hit = hit | (pat[pos] & mask[d[MASK_IDX_W-1:0]]);
            end
        end
        return hit;
    endfunction

    // config registers
    logic [LEN_CFG_W-1:0]   len_cfg_reg, len_cfg_next;
    logic [SLIDE_CFG_W-1:0] slide_cfg_reg, slide_cfg_next;
    logic [SEED_CFG_W-1:0]  seed_cfg_reg, seed_cfg_next;
    logic [MASK_W-1:0]      seed_mask_reg [NUM_MASKS];
    logic [MASK_W-1:0]      seed_mask_next [NUM_MASKS];

    // sequencer and loop counters
    state_t                 state_reg, state_next;
    logic                   query_reg, query_next;
    logic [P_W-1:0]         p_reg, p_next;
    logic [J_W-1:0]         j_reg, j_next;
    logic [S_W-1:0]         s_reg, s_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [MASK_W-1:0]      obs_reg [NUM_MASKS];
    logic [MASK_W-1:0]      obs_next [NUM_MASKS];

    // count table valid bits
    logic [DEPTH-1:0]       valid_reg, valid_next;

    // query scoring stage, one term behind the issue counters
    logic                   pv_reg, pv_next;
    logic                   pred_reg, pred_next;
    logic                   obsbit_reg, obsbit_next;
    logic                   lastc_reg, lastc_next;
    logic                   lastall_reg, lastall_next;
    logic [P_W-1:0]         tp_reg, tp_next;
    logic                   rd_hit_reg, rd_hit_next;
    logic [DIST_W-1:0]      dist_reg, dist_next;
    logic [DIST_W-1:0]      best_d_reg, best_d_next;
    logic [P_W-1:0]         best_p_reg, best_p_next;
    logic                   have_reg, have_next;

    // output word register
    logic                   out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]     out_index_reg, out_index_next;
    logic [PATTERN_W-1:0]   out_pattern_reg, out_pattern_next;
    logic [DIST_W-1:0]      out_dist_reg, out_dist_next;

    // count table
    logic [CNT_W-1:0]       mem [DEPTH];
    logic [CNT_W-1:0]       rd_cnt_reg;
    logic                   mem_we;
    logic [CNT_W-1:0]       mem_wdata;

    // derived values
    logic                   cfg_wr;
    reg_idx_t               cfg_idx;
    logic [LEN_CFG_W-1:0]   len_eff;
    logic [SLIDE_CFG_W-1:0] slides_eff;
    logic [SEED_CFG_W-1:0]  seeds_eff;
    logic [P_W-1:0]         n_m1;
    logic [CNT_W-1:0]       n_cnt;
    logic [L_W-1:0]         pat;
    logic                   pred;
    logic [A_W-1:0]         addr;
    logic                   p_last;
    logic                   j_last;
    logic                   s_last;
    logic                   in_acc;
    logic                   out_free;
    logic [CNT_W-1:0]       cnt_rd;
    logic [CNT_W-1:0]       term;
    logic [DIST_W-1:0]      sum;

    assign pready        = 1'b1;
    assign cfg_wr        = psel & penable & pwrite & pready;
    assign cfg_idx       = paddr[APB_ADDR_W-1:2];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign out_free      = ~out_valid_reg | m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_dist_reg, out_pattern_reg, out_index_reg};

    // out-of-range lengths read as the nearest legal value
    always_comb
    begin
        if (len_cfg_reg == '0)
            len_eff = LEN_CFG_W'(1);
        else if (len_cfg_reg > LEN_CFG_W'(MAX_PATTERN_LEN))
            len_eff = LEN_CFG_W'(MAX_PATTERN_LEN);
        else
            len_eff = len_cfg_reg;

        if (slide_cfg_reg == '0)
            slides_eff = SLIDE_CFG_W'(1);
        else if (slide_cfg_reg > SLIDE_CFG_W'(MAX_SIGNATURE_LEN))
            slides_eff = SLIDE_CFG_W'(MAX_SIGNATURE_LEN);
        else
            slides_eff = slide_cfg_reg;

        if (seed_cfg_reg == '0)
            seeds_eff = SEED_CFG_W'(1);
        else if (seed_cfg_reg > SEED_CFG_W'(NUM_SEEDS))
            seeds_eff = SEED_CFG_W'(NUM_SEEDS);
        else
            seeds_eff = seed_cfg_reg;
    end

    // candidate count minus one is len-1 ones
    assign n_m1   = ~({P_W{1'b1}} << (len_eff - LEN_CFG_W'(1)));
    assign n_cnt  = CNT_W'(n_m1) + CNT_W'(1);

    // shared step unit: one (candidate, seed, slide) prediction
    assign pat    = pattern_of(p_reg, len_eff);
    assign pred   = predict_bit(pat, seed_mask_reg[MASK_SEL_W'(j_reg)], s_reg);
    assign addr   = A_W'(int'(s_reg) * NUM_SEEDS + int'(j_reg));
    assign p_last = (p_reg == n_m1);
    assign j_last = (SEED_CFG_W'(j_reg) == seeds_eff - SEED_CFG_W'(1));
    assign s_last = (SLIDE_CFG_W'(s_reg) == slides_eff - SLIDE_CFG_W'(1));

    // weighted term of the scoring stage
    always_comb
    begin
        cnt_rd = rd_hit_reg ? rd_cnt_reg : '0;
        term   = '0;
        if (pv_reg && (pred_reg != obsbit_reg))
        begin
            if (obsbit_reg)
                term = cnt_rd;
            else if (cnt_rd > n_cnt)
                term = '0;
            else
                term = n_cnt - cnt_rd;
        end
        sum = dist_reg + DIST_W'(term);
    end

    // apb read decode
    always_comb
    begin
        unique case (cfg_idx)
            REG_PATTERN_LEN:   prdata = APB_DATA_W'(len_cfg_reg);
            REG_SIGNATURE_LEN: prdata = APB_DATA_W'(slide_cfg_reg);
            REG_SEED_COUNT:    prdata = APB_DATA_W'(seed_cfg_reg);
            REG_SEED_MASK0:    prdata = seed_mask_reg[0];
            REG_SEED_MASK1:    prdata = seed_mask_reg[1];
            REG_SEED_MASK2:    prdata = seed_mask_reg[2];
            REG_SEED_MASK3:    prdata = seed_mask_reg[3];
            default:           prdata = '0;
        endcase
    end

    always_comb
    begin
        len_cfg_next     = len_cfg_reg;
        slide_cfg_next   = slide_cfg_reg;
        seed_cfg_next    = seed_cfg_reg;
        seed_mask_next   = seed_mask_reg;
        state_next       = state_reg;
        query_next       = query_reg;
        p_next           = p_reg;
        j_next           = j_reg;
        s_next           = s_reg;
        cnt_next         = cnt_reg;
        obs_next         = obs_reg;
        valid_next       = valid_reg;
        pv_next          = 1'b0;
        pred_next        = pred_reg;
        obsbit_next      = obsbit_reg;
        lastc_next       = lastc_reg;
        lastall_next     = lastall_reg;
        tp_next          = tp_reg;
        rd_hit_next      = rd_hit_reg;
        dist_next        = dist_reg;
        best_d_next      = best_d_reg;
        best_p_next      = best_p_reg;
        have_next        = have_reg;
        out_valid_next   = out_valid_reg;
        out_index_next   = out_index_reg;
        out_pattern_next = out_pattern_reg;
        out_dist_next    = out_dist_reg;
        mem_we           = 1'b0;
        mem_wdata        = cnt_reg + CNT_W'(pred);

        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_PATTERN_LEN:   len_cfg_next      = pwdata[LEN_CFG_W-1:0];
                REG_SIGNATURE_LEN: slide_cfg_next    = pwdata[SLIDE_CFG_W-1:0];
                REG_SEED_COUNT:    seed_cfg_next     = pwdata[SEED_CFG_W-1:0];
                REG_SEED_MASK0:    seed_mask_next[0] = pwdata;
                REG_SEED_MASK1:    seed_mask_next[1] = pwdata;
                REG_SEED_MASK2:    seed_mask_next[2] = pwdata;
                REG_SEED_MASK3:    seed_mask_next[3] = pwdata;
                default:           ;
            endcase
        end

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        // scoring stage: fold the term, close the candidate on its last term
        if (pv_reg)
        begin
            if (lastc_reg)
            begin
                dist_next = '0;
                have_next = 1'b1;
                if (!have_reg || (sum <= best_d_reg))
                begin
                    best_d_next = sum;
                    best_p_next = tp_reg;
                end
            end
            else
            begin
                dist_next = sum;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    query_next = (s_axis_tuser == OP_QUERY);
                    p_next     = '0;
                    j_next     = '0;
                    s_next     = '0;
                    cnt_next   = '0;
                    dist_next  = '0;
                    have_next  = 1'b0;
                    for (int k = 0; k < NUM_MASKS; k++)
                    begin
                        obs_next[k] = s_axis_tdata[k*MASK_W +: MASK_W];
                    end
                    if (s_axis_tuser == OP_BUILD)
                    begin
                        valid_next = '0;
                        state_next = ST_BUILD;
                    end
                    else
                    begin
                        state_next = ST_QUERY;
                    end
                end
            end

            // candidates innermost: one count per (slide, seed), written once
            ST_BUILD:
            begin
                if (p_last)
                begin
                    mem_we           = 1'b1;
                    valid_next[addr] = 1'b1;
                    cnt_next         = '0;
                    p_next           = '0;
                    if (j_last)
                    begin
                        j_next = '0;
                        if (s_last)
                            state_next = ST_FINISH;
                        else
                            s_next = s_reg + S_W'(1);
                    end
                    else
                    begin
                        j_next = j_reg + J_W'(1);
                    end
                end
                else
                begin
                    cnt_next = mem_wdata;
                    p_next   = p_reg + P_W'(1);
                end
            end

            // slides innermost: table read issued here, scored next cycle
            ST_QUERY:
            begin
                pv_next      = 1'b1;
                pred_next    = pred;
                obsbit_next  = obs_reg[MASK_SEL_W'(j_reg)][MASK_IDX_W'(s_reg)];
                lastc_next   = j_last & s_last;
                lastall_next = j_last & s_last & p_last;
                tp_next      = p_reg;
                rd_hit_next  = valid_reg[addr];
                if (s_last)
                begin
                    s_next = '0;
                    if (j_last)
                    begin
                        j_next = '0;
                        if (p_last)
                            state_next = ST_DRAIN;
                        else
                            p_next = p_reg + P_W'(1);
                    end
                    else
                    begin
                        j_next = j_reg + J_W'(1);
                    end
                end
                else
                begin
                    s_next = s_reg + S_W'(1);
                end
            end

            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end

            // best candidate is final here; build reports all zeros
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (query_reg)
                    begin
                        out_index_next   = INDEX_W'(best_p_reg);
                        out_pattern_next = PATTERN_W'(pattern_of(best_p_reg, len_eff));
                        out_dist_next    = best_d_reg;
                    end
                    else
                    begin
                        out_index_next   = '0;
                        out_pattern_next = '0;
                        out_dist_next    = '0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg   <= LEN_RESET;
            slide_cfg_reg <= SLIDE_RESET;
            seed_cfg_reg  <= SEED_RESET;
            for (int k = 0; k < NUM_MASKS; k++)
            begin
                seed_mask_reg[k] <= '0;
            end
            state_reg     <= ST_IDLE;
            query_reg     <= 1'b0;
            p_reg         <= '0;
            j_reg         <= '0;
            s_reg         <= '0;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            pv_reg        <= 1'b0;
            lastc_reg     <= 1'b0;
            lastall_reg   <= 1'b0;
            dist_reg      <= '0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_cfg_reg   <= len_cfg_next;
            slide_cfg_reg <= slide_cfg_next;
            seed_cfg_reg  <= seed_cfg_next;
            seed_mask_reg <= seed_mask_next;
            state_reg     <= state_next;
            query_reg     <= query_next;
            p_reg         <= p_next;
            j_reg         <= j_next;
            s_reg         <= s_next;
            cnt_reg       <= cnt_next;
            valid_reg     <= valid_next;
            pv_reg        <= pv_next;
            lastc_reg     <= lastc_next;
            lastall_reg   <= lastall_next;
            dist_reg      <= dist_next;
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        obs_reg         <= obs_next;
        pred_reg        <= pred_next;
        obsbit_reg      <= obsbit_next;
        tp_reg          <= tp_next;
        rd_hit_reg      <= rd_hit_next;
        best_d_reg      <= best_d_next;
        best_p_reg      <= best_p_next;
        out_index_reg   <= out_index_next;
        out_pattern_reg <= out_pattern_next;
        out_dist_reg    <= out_dist_next;
    end

    // count table, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr] <= mem_wdata;
        rd_cnt_reg <= mem[addr];
    end

    `SSPM_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `SSPM_ASSERT_NEXT(a_finish_loads_word, (state_reg == ST_FINISH) && out_free, m_axis_tvalid)
    `SSPM_ASSERT_NOW(a_drain_has_last_term, state_reg == ST_DRAIN, pv_reg && lastall_reg)
    `SSPM_ASSERT_NOW(a_candidate_in_range,
        (state_reg == ST_BUILD) || (state_reg == ST_QUERY), p_reg <= n_m1)
    `SSPM_ASSERT_NEXT(a_build_word_zero,
        (state_reg == ST_FINISH) && out_free && !query_reg, m_axis_tdata == '0)

endmodule
